// ===== hw/rtl/rppsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rppsc_pkg: shared types and constants of the radar point polar converter
// Cell data types, pipeline depths and the CORDIC arctangent steps.
// ----------------------------------------------------------------------------
package rppsc_pkg;

    localparam int DEF_ANGLE_BITS    = 16;
    localparam int DEF_CORDIC_STAGES = 16;

    // Square root chain: two radicand bits per cell.
    localparam int SQ_STAGES = 25;
    // Divider chain: one quotient bit per cell.
    localparam int DIV_STAGES = 16;
    // Normalizing shift: shifts of 16, 8, 4, 2 and 1.
    localparam int NORM_STAGES = 5;
    localparam int NORM_TARGET = 29;
    localparam int MAX_CORDIC  = 24;

    typedef enum logic [2:0] {
        REG_MIN_RANGE  = 3'd0,
        REG_EGO_X      = 3'd1,
        REG_EGO_Y      = 3'd2,
        REG_EGO_Z      = 3'd3,
        REG_STATIC_THR = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [49:0] src;
        logic [24:0] root;
        logic [26:0] rem;
    } sqrt_t;

    typedef struct packed {
        logic [15:0] num;
        logic [24:0] rem;
        logic [24:0] den;
        logic [15:0] quo;
    } div_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic [31:0]        z;
    } cor_t;

    typedef struct packed {
        cor_t        c;
        logic [30:0] mag;
    } norm_t;

    // atan(2^-i), full circle is 2^32.
    function automatic logic [31:0] atan_step(input int i);
        case (i)
            0:       return 32'h20000000;
            1:       return 32'h12E4051E;
            2:       return 32'h09FB385B;
            3:       return 32'h051111D4;
            4:       return 32'h028B0D43;
            5:       return 32'h0145D7E1;
            6:       return 32'h00A2F61E;
            7:       return 32'h00517C55;
            8:       return 32'h0028BE53;
            9:       return 32'h00145F2F;
            10:      return 32'h000A2F98;
            11:      return 32'h000517CC;
            12:      return 32'h00028BE6;
            13:      return 32'h000145F3;
            14:      return 32'h0000A2FA;
            15:      return 32'h0000517D;
            16:      return 32'h000028BE;
            17:      return 32'h0000145F;
            18:      return 32'h00000A30;
            19:      return 32'h00000518;
            20:      return 32'h0000028C;
            21:      return 32'h00000146;
            22:      return 32'h000000A3;
            23:      return 32'h00000051;
            default: return 32'h00000000;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rppsc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rppsc_if: stream channels of the radar point polar converter
// Detection input channel and polar result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rppsc_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] doppler;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output doppler, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input doppler, output ready);
endinterface

interface rppsc_out_if #(
    parameter int ANGLE_BITS = rppsc_pkg::DEF_ANGLE_BITS
);
    logic                         valid;
    logic                         ready;
    logic [23:0]                  range_out;
    logic signed [ANGLE_BITS-1:0] azimuth;
    logic signed [ANGLE_BITS-1:0] elevation;
    logic signed [15:0]           dir_x;
    logic signed [15:0]           dir_y;
    logic signed [15:0]           dir_z;
    logic                         is_static;
    logic                         too_close;

    modport source (output valid, output range_out, output azimuth, output elevation,
                    output dir_x, output dir_y, output dir_z, output is_static,
                    output too_close, input ready);
    modport sink   (input valid, input range_out, input azimuth, input elevation,
                    input dir_x, input dir_y, input dir_z, input is_static,
                    input too_close, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rppsc_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rppsc_sqrt_cell: one step of a pipelined integer square root
// Brings in two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module rppsc_sqrt_cell (
    input  logic              clk,
    input  logic              en,
    input  rppsc_pkg::sqrt_t  d,
    output rppsc_pkg::sqrt_t  q
);
    rppsc_pkg::sqrt_t cell_reg;
    rppsc_pkg::sqrt_t cell_next;
    logic [28:0]      rem2;
    logic [28:0]      trial;

    always_comb
    begin
        rem2          = {d.rem, d.src[49:48]};
        trial         = {2'b00, d.root, 2'b01};
        cell_next.src = {d.src[47:0], 2'b00};
        if (rem2 >= trial)
        begin
            cell_next.rem  = 27'(rem2 - trial);
            cell_next.root = {d.root[23:0], 1'b1};
        end
        else
        begin
            cell_next.rem  = rem2[26:0];
            cell_next.root = {d.root[23:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign q = cell_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/rppsc_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rppsc_div_cell: one step of a pipelined restoring divider
// Produces one quotient bit when active, otherwise passes its operand on unchanged.
// ----------------------------------------------------------------------------
module rppsc_div_cell #(
    parameter bit ACTIVE = 1'b1
) (
    input  logic             clk,
    input  logic             en,
    input  rppsc_pkg::div_t  d,
    output rppsc_pkg::div_t  q
);
    rppsc_pkg::div_t cell_reg;
    rppsc_pkg::div_t cell_next;
    logic [25:0]     rem2;

    always_comb
    begin
        rem2      = {d.rem, d.num[15]};
        cell_next = d;
        if (ACTIVE)
        begin
            cell_next.num = {d.num[14:0], 1'b0};
            if (rem2 >= {1'b0, d.den})
            begin
                cell_next.rem = 25'(rem2 - {1'b0, d.den});
                cell_next.quo = {d.quo[14:0], 1'b1};
            end
            else
            begin
                cell_next.rem = rem2[24:0];
                cell_next.quo = {d.quo[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign q = cell_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/rppsc_norm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rppsc_norm_cell: one step of the CORDIC operand normalizing shift
// Shifts the vector left by a fixed amount if it stays below twice the target.
// ----------------------------------------------------------------------------
module rppsc_norm_cell #(
    parameter int AMT = 16
) (
    input  logic              clk,
    input  logic              en,
    input  rppsc_pkg::norm_t  d,
    output rppsc_pkg::norm_t  q
);
    rppsc_pkg::norm_t cell_reg;
    rppsc_pkg::norm_t cell_next;

    always_comb
    begin
        cell_next = d;
        if (d.mag < (31'(1) << (rppsc_pkg::NORM_TARGET + 1 - AMT)))
        begin
            cell_next.c.x = d.c.x <<< AMT;
            cell_next.c.y = d.c.y <<< AMT;
            cell_next.mag = d.mag << AMT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign q = cell_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/rppsc_cordic_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rppsc_cordic_cell: one CORDIC vectoring iteration
// Rotates toward the x axis by atan(2^-SHIFT) when active, else passes it on unchanged.
// ----------------------------------------------------------------------------
module rppsc_cordic_cell #(
    parameter int SHIFT  = 0,
    parameter bit ACTIVE = 1'b1
) (
    input  logic             clk,
    input  logic             en,
    input  rppsc_pkg::cor_t  d,
    output rppsc_pkg::cor_t  q
);
    localparam logic [31:0] ANG = rppsc_pkg::atan_step(SHIFT);

    rppsc_pkg::cor_t    cell_reg;
    rppsc_pkg::cor_t    cell_next;
    logic signed [33:0] xs;
    logic signed [33:0] ys;

    always_comb
    begin
        xs        = d.x;
        ys        = d.y;
        cell_next = d;
        if (ACTIVE)
        begin
            if (!ys[33])
            begin
                cell_next.x = xs + (ys >>> SHIFT);
                cell_next.y = ys - (xs >>> SHIFT);
                cell_next.z = d.z + ANG;
            end
            else
            begin
                cell_next.x = xs - (ys >>> SHIFT);
                cell_next.y = ys + (xs >>> SHIFT);
                cell_next.z = d.z - ANG;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign q = cell_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/radar_point_polar_static_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// radar_point_polar_static_check: radar detection to polar form, static check
// Range, azimuth, elevation and unit direction of one detection per beat,
// with a Doppler residual test against the configured ego velocity.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields                                          | beat
//  --------+-----+-------------------------------------------------+---------
//  det     | in  | pos_x, pos_y, pos_z, doppler                    | 1 point
//  res     | out | range_out, azimuth, elevation, dir_x/y/z,       | 1 result
//          |     | is_static, too_close                            |
//  cfg     | in  | cfg_we, cfg_idx, cfg_data                       | 1 write
//
// One beat is accepted every cycle while the output register is empty or its
// result is taken. The chain is built from the 25 square root cells, the 5
// normalizing cells and the shared row of CORDIC and divider cells.
// Reset clears the valid bits of every stage and loads the register defaults.
// When the result at the output is not taken, the whole chain holds.
// ----------------------------------------------------------------------------
module radar_point_polar_static_check #(
    parameter int ANGLE_BITS    = rppsc_pkg::DEF_ANGLE_BITS,
    parameter int CORDIC_STAGES = rppsc_pkg::DEF_CORDIC_STAGES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [15:0] cfg_data,
    rppsc_in_if.sink    det,
    rppsc_out_if.source res
);
    localparam int SQ  = rppsc_pkg::SQ_STAGES;
    localparam int NRM = rppsc_pkg::NORM_STAGES;
    localparam int DVS = rppsc_pkg::DIV_STAGES;
    localparam int L   = (CORDIC_STAGES > DVS) ? CORDIC_STAGES : DVS;
    localparam int NST = SQ + NRM + L + 6;
    localparam int SH  = 32 - ANGLE_BITS;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic signed [15:0] dop;
    } item_t;

    typedef struct packed {
        logic [2:0]         neg;
        logic               close;
        logic signed [15:0] dop;
        logic               az_zero;
        logic               el_zero;
        logic [23:0]        rng;
    } side_t;

    // ------------------------------------------------------------------
    // Configuration registers. Writes must arrive only while the chain is idle; the block itself does not enforce this.
    // ------------------------------------------------------------------
    logic [7:0]         min_range_reg;
    logic signed [15:0] ego_x_reg;
    logic signed [15:0] ego_y_reg;
    logic signed [15:0] ego_z_reg;
    logic [14:0]        thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg <= 8'd1;
            ego_x_reg     <= '0;
            ego_y_reg     <= '0;
            ego_z_reg     <= '0;
            thr_reg       <= 15'd128;
        end
        else if (cfg_we)
        begin
            unique case (rppsc_pkg::reg_idx_t'(cfg_idx))
                rppsc_pkg::REG_MIN_RANGE:  min_range_reg <= cfg_data[7:0];
                rppsc_pkg::REG_EGO_X:      ego_x_reg     <= cfg_data;
                rppsc_pkg::REG_EGO_Y:      ego_y_reg     <= cfg_data;
                rppsc_pkg::REG_EGO_Z:      ego_z_reg     <= cfg_data;
                rppsc_pkg::REG_STATIC_THR: thr_reg       <= cfg_data[14:0];
                default:                   ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: every stage moves together. The chain advances
    // whenever the output register is empty or its result is taken.
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic           adv;

    assign adv       = !vld_reg[NST-1] || res.ready;
    assign det.ready = adv;
    assign res.valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], det.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage A: squares of the coordinates and the two radicands.
    // ------------------------------------------------------------------
    logic signed [47:0] xx;
    logic signed [47:0] yy;
    logic signed [47:0] zz;
    logic [47:0]        a_hsq_next;
    logic [48:0]        a_ssq_next;
    item_t              a_item_reg;
    logic [47:0]        a_hsq_reg;
    logic [48:0]        a_ssq_reg;

    assign xx         = det.pos_x * det.pos_x;
    assign yy         = det.pos_y * det.pos_y;
    assign zz         = det.pos_z * det.pos_z;
    assign a_hsq_next = $unsigned(xx) + $unsigned(yy);
    assign a_ssq_next = {1'b0, a_hsq_next} + {1'b0, $unsigned(zz)};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= '{x: det.pos_x, y: det.pos_y, z: det.pos_z, dop: det.doppler};
            a_hsq_reg  <= a_hsq_next;
            a_ssq_reg  <= a_ssq_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root rows: full range and horizontal distance side by side.
    // ------------------------------------------------------------------
    rppsc_pkg::sqrt_t rs_c [0:SQ];
    rppsc_pkg::sqrt_t hs_c [0:SQ];
    item_t            sq_item_reg [0:SQ-1];

    assign rs_c[0] = '{src: {1'b0, a_ssq_reg}, root: '0, rem: '0};
    assign hs_c[0] = '{src: {2'b00, a_hsq_reg}, root: '0, rem: '0};

    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        rppsc_sqrt_cell u_rs (.clk(clk), .en(adv), .d(rs_c[k]), .q(rs_c[k+1]));
        rppsc_sqrt_cell u_hs (.clk(clk), .en(adv), .d(hs_c[k]), .q(hs_c[k+1]));
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_item_reg[k] <= a_item_reg;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_item_reg[k] <= sq_item_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage P: round both roots to nearest, saturate the range and
    // decide whether the point is too close.
    // ------------------------------------------------------------------
    logic [25:0] rng_full;
    logic [23:0] rng_sat;
    logic [24:0] h_next;
    logic        close_next;
    item_t       p_item_reg;
    logic [23:0] p_rng_reg;
    logic [24:0] p_h_reg;
    logic        p_close_reg;

    assign rng_full   = {1'b0, rs_c[SQ].root}
                      + 26'(rs_c[SQ].rem > {2'b00, rs_c[SQ].root});
    assign rng_sat    = (rng_full > 26'hFFFFFF) ? 24'hFFFFFF : rng_full[23:0];
    assign h_next     = hs_c[SQ].root + 25'(hs_c[SQ].rem > {2'b00, hs_c[SQ].root});
    assign close_next = (rng_sat < {16'b0, min_range_reg}) || (rng_sat == '0);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_item_reg  <= sq_item_reg[SQ-1];
            p_rng_reg   <= rng_sat;
            p_h_reg     <= h_next;
            p_close_reg <= close_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage Q: set up the three direction divisions, computing
    // (|p| * 2^15 + range) / (2 * range), and the two CORDIC vectors.
    // The azimuth vector is turned by pi when x is negative.
    // ------------------------------------------------------------------
    logic signed [23:0]         pv [0:2];
    logic [23:0]                av [0:2];
    logic [38:0]                numv [0:2];
    rppsc_pkg::div_t [2:0]      q_dv_next;
    rppsc_pkg::norm_t           q_az_next;
    rppsc_pkg::norm_t           q_el_next;
    logic signed [33:0]         azx;
    logic signed [33:0]         azy;
    logic [33:0]                azy_abs;
    logic [23:0]                z_abs;
    rppsc_pkg::div_t [2:0]      q_dv_reg;
    rppsc_pkg::norm_t           q_az_reg;
    rppsc_pkg::norm_t           q_el_reg;
    side_t                      q_side_reg;

    assign pv[0] = p_item_reg.x;
    assign pv[1] = p_item_reg.y;
    assign pv[2] = p_item_reg.z;

    for (genvar l = 0; l < 3; l++)
    begin : g_prep
        assign av[l]   = pv[l][23] ? 24'(-pv[l]) : 24'(pv[l]);
        assign numv[l] = {av[l], 15'b0} + {15'b0, p_rng_reg};
        assign q_dv_next[l] = '{num: numv[l][15:0], rem: {2'b00, numv[l][38:16]},
                                den: {p_rng_reg, 1'b0}, quo: '0};
    end

    always_comb
    begin
        azx = 34'(p_item_reg.x);
        azy = 34'(p_item_reg.y);
        q_az_next.c.z = '0;
        if (p_item_reg.x[23])
        begin
            azx = -azx;
            azy = -azy;
            q_az_next.c.z = 32'h80000000;
        end
        azy_abs       = azy[33] ? 34'(-azy) : 34'(azy);
        q_az_next.c.x = azx;
        q_az_next.c.y = azy;
        q_az_next.mag = ($unsigned(azx) > azy_abs) ? azx[30:0] : azy_abs[30:0];

        z_abs         = av[2];
        q_el_next.c.x = {9'b0, p_h_reg};
        q_el_next.c.y = 34'(p_item_reg.z);
        q_el_next.c.z = '0;
        q_el_next.mag = ({1'b0, z_abs} > p_h_reg) ? {7'b0, z_abs} : {6'b0, p_h_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_dv_reg   <= q_dv_next;
            q_az_reg   <= q_az_next;
            q_el_reg   <= q_el_next;
            q_side_reg <= '{neg: {p_item_reg.z[23], p_item_reg.y[23], p_item_reg.x[23]},
                            close: p_close_reg, dop: p_item_reg.dop,
                            az_zero: (q_az_next.mag == '0),
                            el_zero: (q_el_next.mag == '0), rng: p_rng_reg};
        end
    end

    // ------------------------------------------------------------------
    // Normalizing rows: double the vectors until the larger magnitude
    // lies in [2^29, 2^30). The division operands ride along unchanged.
    // ------------------------------------------------------------------
    rppsc_pkg::norm_t      az_n [0:NRM];
    rppsc_pkg::norm_t      el_n [0:NRM];
    rppsc_pkg::div_t [2:0] nd_reg [0:NRM-1];
    side_t                 sd_reg [0:NRM+L-1];

    assign az_n[0] = q_az_reg;
    assign el_n[0] = q_el_reg;

    for (genvar j = 0; j < NRM; j++)
    begin : g_norm
        rppsc_norm_cell #(.AMT(16 >> j)) u_az (.clk(clk), .en(adv), .d(az_n[j]),
                                               .q(az_n[j+1]));
        rppsc_norm_cell #(.AMT(16 >> j)) u_el (.clk(clk), .en(adv), .d(el_n[j]),
                                               .q(el_n[j+1]));
        if (j == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    nd_reg[j] <= q_dv_reg;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    nd_reg[j] <= nd_reg[j-1];
                end
            end
        end
    end

    for (genvar s = 0; s < NRM + L; s++)
    begin : g_side
        if (s == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sd_reg[s] <= q_side_reg;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sd_reg[s] <= sd_reg[s-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main row: cell k runs CORDIC iteration k for both angles while k < CORDIC_STAGES and
    // one quotient bit for each of the three direction components while k < DIV_STAGES.
    // ------------------------------------------------------------------
    rppsc_pkg::cor_t az_c [0:L];
    rppsc_pkg::cor_t el_c [0:L];
    rppsc_pkg::div_t dv_c [0:2][0:L];

    assign az_c[0] = az_n[NRM].c;
    assign el_c[0] = el_n[NRM].c;

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        assign dv_c[l][0] = nd_reg[NRM-1][l];
        for (genvar k = 0; k < L; k++)
        begin : g_div
            rppsc_div_cell #(.ACTIVE(k < DVS)) u_div (.clk(clk), .en(adv),
                                                      .d(dv_c[l][k]), .q(dv_c[l][k+1]));
        end
    end

    for (genvar k = 0; k < L; k++)
    begin : g_cordic
        rppsc_cordic_cell #(.SHIFT(k), .ACTIVE(k < CORDIC_STAGES)) u_az (
            .clk(clk), .en(adv), .d(az_c[k]), .q(az_c[k+1]));
        rppsc_cordic_cell #(.SHIFT(k), .ACTIVE(k < CORDIC_STAGES)) u_el (
            .clk(clk), .en(adv), .d(el_c[k]), .q(el_c[k+1]));
    end

    // ------------------------------------------------------------------
    // Stage F: round the angles, clamp and sign the direction
    // components, and zero all of them for a point that is too close.
    // ------------------------------------------------------------------
    side_t                        sd_end;
    logic [31:0]                  az_round;
    logic [31:0]                  el_round;
    logic [14:0]                  qc [0:2];
    logic signed [15:0]           dir_next [0:2];
    logic signed [15:0]           f_dir_reg [0:2];
    logic signed [ANGLE_BITS-1:0] f_az_reg;
    logic signed [ANGLE_BITS-1:0] f_el_reg;
    logic [23:0]                  f_rng_reg;
    logic                         f_close_reg;
    logic signed [15:0]           f_dop_reg;

    assign sd_end   = sd_reg[NRM+L-1];
    assign az_round = az_c[L].z + (32'(1) << (SH - 1));
    assign el_round = el_c[L].z + (32'(1) << (SH - 1));

    for (genvar l = 0; l < 3; l++)
    begin : g_dir
        assign qc[l] = (dv_c[l][L].quo > 16'd16384) ? 15'd16384 : dv_c[l][L].quo[14:0];
        assign dir_next[l] = sd_end.close ? 16'sd0 :
                             sd_end.neg[l] ? -$signed({1'b0, qc[l]}) : $signed({1'b0, qc[l]});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                f_dir_reg[l] <= dir_next[l];
            end
            f_az_reg    <= (sd_end.close || sd_end.az_zero) ? '0 : az_round[31:SH];
            f_el_reg    <= (sd_end.close || sd_end.el_zero) ? '0 : el_round[31:SH];
            f_rng_reg   <= sd_end.rng;
            f_close_reg <= sd_end.close;
            f_dop_reg   <= sd_end.dop;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: ego velocity times direction, one multiplier per axis.
    // ------------------------------------------------------------------
    logic signed [31:0]           g_prod_reg [0:2];
    logic signed [29:0]           g_dop_reg;
    logic signed [15:0]           g_dir_reg [0:2];
    logic signed [ANGLE_BITS-1:0] g_az_reg;
    logic signed [ANGLE_BITS-1:0] g_el_reg;
    logic [23:0]                  g_rng_reg;
    logic                         g_close_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_prod_reg[0] <= ego_x_reg * f_dir_reg[0];
            g_prod_reg[1] <= ego_y_reg * f_dir_reg[1];
            g_prod_reg[2] <= ego_z_reg * f_dir_reg[2];
            g_dop_reg     <= {f_dop_reg, 14'b0};
            for (int l = 0; l < 3; l++)
            begin
                g_dir_reg[l] <= f_dir_reg[l];
            end
            g_az_reg    <= f_az_reg;
            g_el_reg    <= f_el_reg;
            g_rng_reg   <= f_rng_reg;
            g_close_reg <= f_close_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage H, the output register: the Doppler residual is compared
    // exactly against the threshold scaled by 2^14.
    // ------------------------------------------------------------------
    logic signed [33:0]           resid;
    logic [33:0]                  resid_abs;
    logic [23:0]                  h_rng_reg;
    logic signed [ANGLE_BITS-1:0] h_az_reg;
    logic signed [ANGLE_BITS-1:0] h_el_reg;
    logic signed [15:0]           h_dir_reg [0:2];
    logic                         h_static_reg;
    logic                         h_close_reg;

    assign resid     = 34'(g_dop_reg) + 34'(g_prod_reg[0]) + 34'(g_prod_reg[1])
                     + 34'(g_prod_reg[2]);
    assign resid_abs = resid[33] ? 34'(-resid) : 34'(resid);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_rng_reg    <= g_rng_reg;
            h_az_reg     <= g_az_reg;
            h_el_reg     <= g_el_reg;
            for (int l = 0; l < 3; l++)
            begin
                h_dir_reg[l] <= g_dir_reg[l];
            end
            h_static_reg <= (resid_abs < {5'b0, thr_reg, 14'b0});
            h_close_reg  <= g_close_reg;
        end
    end

    assign res.range_out = h_rng_reg;
    assign res.azimuth   = h_az_reg;
    assign res.elevation = h_el_reg;
    assign res.dir_x     = h_dir_reg[0];
    assign res.dir_y     = h_dir_reg[1];
    assign res.dir_z     = h_dir_reg[2];
    assign res.is_static = h_static_reg;
    assign res.too_close = h_close_reg;
endmodule
`default_nettype wire
